// ===== hw/rtl/ctc_pkg.sv =====
// Shared types, constants and helper functions for the child transform compose block.
`timescale 1ns / 1ps
`default_nettype none

package ctc_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int ATAN_ENTRIES      = 24;

  // CORDIC limit gain 0.60725... in Q2.30
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  // Work item carried down the pipe next to the CORDIC state
  typedef struct packed {
    logic               ok;
    logic               flip;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        wa;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } ctc_pay_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic signed [31:0] atan_turn(input int i);
    logic signed [31:0] r;
    case (i)
      0:       r = 32'sh20000000;
      1:       r = 32'sh12E4051E;
      2:       r = 32'sh09FB385B;
      3:       r = 32'sh051111D4;
      4:       r = 32'sh028B0D43;
      5:       r = 32'sh0145D7E1;
      6:       r = 32'sh00A2F61E;
      7:       r = 32'sh00517C55;
      8:       r = 32'sh0028BE53;
      9:       r = 32'sh00145F2F;
      10:      r = 32'sh000A2F98;
      11:      r = 32'sh000517CC;
      12:      r = 32'sh00028BE6;
      13:      r = 32'sh000145F3;
      14:      r = 32'sh0000A2FA;
      15:      r = 32'sh0000517D;
      16:      r = 32'sh000028BE;
      17:      r = 32'sh0000145F;
      18:      r = 32'sh00000A30;
      19:      r = 32'sh00000518;
      20:      r = 32'sh0000028C;
      21:      r = 32'sh00000146;
      22:      r = 32'sh000000A3;
      23:      r = 32'sh00000051;
      default: r = 32'sh00000000;
    endcase
    return r;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ctc_if.sv =====
// Valid/ready stream interfaces for child records and world transform results.
`timescale 1ns / 1ps
`default_nettype none

interface ctc_in_if;
  logic               valid;
  logic               ready;
  logic               parent_ok;
  logic signed [31:0] parent_x;
  logic signed [31:0] parent_y;
  logic [15:0]        parent_angle;
  logic signed [31:0] parent_scale_x;
  logic signed [31:0] parent_scale_y;
  logic signed [31:0] local_x;
  logic signed [31:0] local_y;
  logic [15:0]        local_angle;

  modport source (
    output valid, parent_ok, parent_x, parent_y, parent_angle,
           parent_scale_x, parent_scale_y, local_x, local_y, local_angle,
    input  ready
  );
  modport sink (
    input  valid, parent_ok, parent_x, parent_y, parent_angle,
           parent_scale_x, parent_scale_y, local_x, local_y, local_angle,
    output ready
  );
endinterface

interface ctc_out_if;
  logic               valid;
  logic               ready;
  logic               updated;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic [15:0]        world_angle;

  modport source (
    output valid, updated, world_x, world_y, world_angle,
    input  ready
  );
  modport sink (
    input  valid, updated, world_x, world_y, world_angle,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/ctc_cordic_pipe.sv =====
// Rotation-mode CORDIC, one registered iteration per stage, payload carried alongside.
`timescale 1ns / 1ps
`default_nettype none

module ctc_cordic_pipe #(
  parameter int STAGES = ctc_pkg::CORDIC_STAGES_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire [STAGES-1:0]     en_i,
  input  wire                  valid_i,
  input  ctc_pkg::ctc_pay_t    pay_i,
  input  wire signed [31:0]    z0_i,
  output logic [STAGES-1:0]    valid_o,
  output ctc_pkg::ctc_pay_t    pay_o,
  output logic signed [31:0]   x_o,
  output logic signed [31:0]   y_o
);

  logic [STAGES-1:0]  v_q;
  logic signed [31:0] x_q   [STAGES];
  logic signed [31:0] y_q   [STAGES];
  logic signed [31:0] z_q   [STAGES];
  ctc_pkg::ctc_pay_t  pay_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic               v_in;
    logic signed [31:0] x_in, y_in, z_in;
    logic signed [31:0] x_d, y_d, z_d;
    ctc_pkg::ctc_pay_t  pay_in;

    if (i == 0) begin : g_first
      assign v_in   = valid_i;
      assign x_in   = ctc_pkg::CORDIC_GAIN;
      assign y_in   = 32'sd0;
      assign z_in   = z0_i;
      assign pay_in = pay_i;
    end else begin : g_next
      assign v_in   = v_q[i-1];
      assign x_in   = x_q[i-1];
      assign y_in   = y_q[i-1];
      assign z_in   = z_q[i-1];
      assign pay_in = pay_q[i-1];
    end

    // z >= 0 rotates counterclockwise
    always_comb begin
      if (!z_in[31]) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - ctc_pkg::atan_turn(i);
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + ctc_pkg::atan_turn(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i[i]) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        x_q[i]   <= x_d;
        y_q[i]   <= y_d;
        z_q[i]   <= z_d;
        pay_q[i] <= pay_in;
      end
    end
  end

  assign valid_o = v_q;
  assign pay_o   = pay_q[STAGES-1];
  assign x_o     = x_q[STAGES-1];
  assign y_o     = y_q[STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/child_transform_compose_2d_unit.sv =====
// Child world transform: scale, CORDIC rotate and translate pipeline, one beat per cycle unless stalled.
// An accepted input beat passes stage 0, the CORDIC stages, M1, M2 and the output register.
// Throughput: one beat per cycle while the output is not stalled; the depth is set by one CORDIC iteration per stage.
// Each stage advances when empty or when the stage after it moves, so bubbles collapse
// and a stalled output holds the pipe without losing or repeating beats.
// Reset clears all stage valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module child_transform_compose_2d_unit #(
  parameter int CORDIC_STAGES = ctc_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_BITS    = ctc_pkg::ANGLE_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  ctc_in_if.sink      in_i,
  ctc_out_if.source   out_o
);

  localparam int NS = (CORDIC_STAGES < ctc_pkg::ATAN_ENTRIES) ?
                      CORDIC_STAGES : ctc_pkg::ATAN_ENTRIES;
  localparam int AW = ANGLE_BITS;
  localparam int L  = NS + 4;

  logic [L-1:0] v;
  logic [L-1:0] en;

  // ---------------- stage 0: scale products, angle prep
  logic [AW-1:0]      pa, la, wsum;
  logic [31:0]        a;
  logic               flip;
  logic signed [31:0] z0;
  logic signed [63:0] prod_x, prod_y;

  logic               v0_q;
  logic signed [63:0] s0_prod_x_q, s0_prod_y_q;
  logic signed [31:0] s0_z0_q;
  logic               s0_flip_q, s0_ok_q;
  logic signed [31:0] s0_px_q, s0_py_q;
  logic [15:0]        s0_wa_q;

  always_comb begin
    pa   = AW'(in_i.parent_angle);
    la   = AW'(in_i.local_angle);
    wsum = pa + la;
    a    = {pa, {(32 - AW){1'b0}}};
    // second and third quadrant: rotate by a half turn, negate later
    flip = a[31] ^ a[30];
    z0   = {a[31] ^ flip, a[30:0]};
    prod_x = in_i.local_x * in_i.parent_scale_x;
    prod_y = in_i.local_y * in_i.parent_scale_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en[0]) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_prod_x_q <= prod_x;
      s0_prod_y_q <= prod_y;
      s0_z0_q     <= z0;
      s0_flip_q   <= flip;
      s0_ok_q     <= in_i.parent_ok;
      s0_px_q     <= in_i.parent_x;
      s0_py_q     <= in_i.parent_y;
      s0_wa_q     <= 16'(wsum);
    end
  end

  // ---------------- CORDIC stages, scaled offset saturates on entry
  ctc_pkg::ctc_pay_t  cp_pay_in, cp_pay_out;
  logic signed [31:0] cp_x, cp_y;
  logic [NS-1:0]      cp_v;

  always_comb begin
    cp_pay_in.ok   = s0_ok_q;
    cp_pay_in.flip = s0_flip_q;
    cp_pay_in.px   = s0_px_q;
    cp_pay_in.py   = s0_py_q;
    cp_pay_in.wa   = s0_wa_q;
    cp_pay_in.sx   = ctc_pkg::sat32(66'(s0_prod_x_q >>> 16));
    cp_pay_in.sy   = ctc_pkg::sat32(66'(s0_prod_y_q >>> 16));
  end

  ctc_cordic_pipe #(
    .STAGES (NS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[NS:1]),
    .valid_i (v0_q),
    .pay_i   (cp_pay_in),
    .z0_i    (s0_z0_q),
    .valid_o (cp_v),
    .pay_o   (cp_pay_out),
    .x_o     (cp_x),
    .y_o     (cp_y)
  );

  // ---------------- M1: rotation products
  logic signed [31:0] cs_c, cs_s;
  logic               vm1_q;
  logic signed [63:0] m1_sxc_q, m1_sys_q, m1_sxs_q, m1_syc_q;
  ctc_pkg::ctc_pay_t  m1_pay_q;

  assign cs_c = cp_pay_out.flip ? -cp_x : cp_x;
  assign cs_s = cp_pay_out.flip ? -cp_y : cp_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm1_q <= 1'b0;
    end else if (en[NS+1]) begin
      vm1_q <= cp_v[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS+1]) begin
      m1_sxc_q <= cp_pay_out.sx * cs_c;
      m1_sys_q <= cp_pay_out.sy * cs_s;
      m1_sxs_q <= cp_pay_out.sx * cs_s;
      m1_syc_q <= cp_pay_out.sy * cs_c;
      m1_pay_q <= cp_pay_out;
    end
  end

  // ---------------- M2: combine, drop Q2.30 fraction, saturate
  logic signed [64:0] sum_x, sum_y;
  logic               vm2_q;
  logic signed [31:0] m2_rx_q, m2_ry_q;
  ctc_pkg::ctc_pay_t  m2_pay_q;

  assign sum_x = 65'(m1_sxc_q) - 65'(m1_sys_q);
  assign sum_y = 65'(m1_sxs_q) + 65'(m1_syc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm2_q <= 1'b0;
    end else if (en[NS+2]) begin
      vm2_q <= vm1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS+2]) begin
      m2_rx_q  <= ctc_pkg::sat32(66'(sum_x >>> 30));
      m2_ry_q  <= ctc_pkg::sat32(66'(sum_y >>> 30));
      m2_pay_q <= m1_pay_q;
    end
  end

  // ---------------- output register: translate, orphan records read as zero
  logic signed [32:0] pos_x, pos_y;
  logic               vout_q;
  logic               updated_q;
  logic signed [31:0] world_x_q, world_y_q;
  logic [15:0]        world_angle_q;

  assign pos_x = 33'(m2_pay_q.px) + 33'(m2_rx_q);
  assign pos_y = 33'(m2_pay_q.py) + 33'(m2_ry_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en[L-1]) begin
      vout_q <= vm2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[L-1]) begin
      updated_q <= m2_pay_q.ok;
      if (m2_pay_q.ok) begin
        world_x_q     <= ctc_pkg::sat32(66'(pos_x));
        world_y_q     <= ctc_pkg::sat32(66'(pos_y));
        world_angle_q <= m2_pay_q.wa;
      end else begin
        world_x_q     <= 32'sd0;
        world_y_q     <= 32'sd0;
        world_angle_q <= 16'd0;
      end
    end
  end

  // ---------------- stage advance chain
  always_comb begin
    v[0]        = v0_q;
    v[NS:1]     = cp_v;
    v[NS+1]     = vm1_q;
    v[NS+2]     = vm2_q;
    v[L-1]      = vout_q;
    en[L-1]     = !v[L-1] || out_o.ready;
    for (int k = L - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_i.ready        = en[0];
  assign out_o.valid       = vout_q;
  assign out_o.updated     = updated_q;
  assign out_o.world_x     = world_x_q;
  assign out_o.world_y     = world_y_q;
  assign out_o.world_angle = world_angle_q;

  // ---------------- assertions
  a_orphan_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.updated) |->
      (out_o.world_x == 32'sd0 && out_o.world_y == 32'sd0 && out_o.world_angle == 16'd0)
  ) else $error("orphan beat carries nonzero world fields");

  a_stall_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&v && !out_o.ready)
  ) else $error("input stalled while pipe has a free stage");

  a_empty_ready: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (v == '0) |-> in_i.ready
  ) else $error("empty pipe refuses input");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the child transform compose unit: random and corner records, predicted results.
`timescale 1ns / 1ps

module tb;

  localparam int     STAGES      = ctc_pkg::CORDIC_STAGES_DEF;
  localparam int     ANGLE_BITS  = ctc_pkg::ANGLE_BITS_DEF;
  localparam int     LATENCY     = STAGES + 4;
  localparam int     ATAN_N      = 24;
  localparam int     HOLD_CYCLES = 90;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [31:0] ANG_MASK = (32'd1 << ANGLE_BITS) - 32'd1;
  localparam logic signed [63:0] GAIN_Q30 = 64'sd652032874;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        pa;
    logic signed [31:0] scx;
    logic signed [31:0] scy;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic [15:0]        la;
  } child_rec_t;

  typedef struct packed {
    logic               updated;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic [15:0]        wa;
  } world_xform_t;

  class world_xform_board;
    world_xform_t pending_world[$];
    longint       atan_turn32[ATAN_N];
    int           errors;
    int           checked;
    int           children;
    int           orphans;

    function new();
      atan_turn32 = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
      errors   = 0;
      checked  = 0;
      children = 0;
      orphans  = 0;
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) begin
        return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
        return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    // Rotation-mode CORDIC, cos/sin in Q2.30
    function void cos_sin(logic [15:0] ang, output longint c, output longint s);
      logic [31:0] a;
      logic [31:0] t;
      logic        flip;
      longint      x;
      longint      y;
      longint      z;
      longint      dx;
      longint      dy;
      a = ({16'h0, ang} & ANG_MASK) << (32 - ANGLE_BITS);
      t = a + 32'h40000000;
      flip = t[31];
      // second and third quadrant: turn by half a turn, negate at the end
      if (flip) begin
        a = a + 32'h80000000;
      end
      z = $signed(a);
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < STAGES && i < ATAN_N; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - atan_turn32[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + atan_turn32[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function world_xform_t compose_world(child_rec_t r);
      world_xform_t w;
      longint       sx;
      longint       sy;
      longint       c;
      longint       s;
      longint       rx;
      longint       ry;
      logic [31:0]  ang_sum;
      w = '0;
      if (!r.ok) begin
        return w;
      end
      sx = clamp32((longint'(r.lx) * longint'(r.scx)) >>> 16);
      sy = clamp32((longint'(r.ly) * longint'(r.scy)) >>> 16);
      cos_sin(r.pa, c, s);
      rx = clamp32((sx * c - sy * s) >>> 30);
      ry = clamp32((sx * s + sy * c) >>> 30);
      ang_sum = (({16'h0, r.pa} & ANG_MASK) + ({16'h0, r.la} & ANG_MASK)) & ANG_MASK;
      w.updated = 1'b1;
      w.wx = clamp32(longint'(r.px) + rx);
      w.wy = clamp32(longint'(r.py) + ry);
      w.wa = ang_sum[15:0];
      return w;
    endfunction

    task report(string what, longint want, longint got);
      errors++;
      if (errors <= 40) begin
        $display("%0t: MISMATCH %s: want %0d got %0d", $time, what, want, got);
      end
    endtask

    function void note_child(child_rec_t r);
      children++;
      if (!r.ok) begin
        orphans++;
      end
      pending_world.push_back(compose_world(r));
    endfunction

    task check_result(world_xform_t got);
      world_xform_t want;
      if (pending_world.size() == 0) begin
        report("result beat with nothing pending, world_x", 0, got.wx);
        return;
      end
      want = pending_world.pop_front();
      checked++;
      if (got.updated !== want.updated) report("updated", want.updated, got.updated);
      if (got.wx !== want.wx) report("world_x", want.wx, got.wx);
      if (got.wy !== want.wy) report("world_y", want.wy, got.wy);
      if (got.wa !== want.wa) report("world_angle", want.wa, got.wa);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  ctc_in_if  in_if ();
  ctc_out_if out_if ();

  child_transform_compose_2d_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  world_xform_board board;
  int     tx_idle_pct;
  int     rx_idle_pct;
  logic   hold_req;
  int     hold_left;
  int     hold_count;
  longint cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending", cycles,
               board.pending_world.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // beat monitor: inputs feed the prediction, outputs are checked against it
  always @(posedge clk_i) begin
    child_rec_t   r;
    world_xform_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        r.ok  = in_if.parent_ok;
        r.px  = in_if.parent_x;
        r.py  = in_if.parent_y;
        r.pa  = in_if.parent_angle;
        r.scx = in_if.parent_scale_x;
        r.scy = in_if.parent_scale_y;
        r.lx  = in_if.local_x;
        r.ly  = in_if.local_y;
        r.la  = in_if.local_angle;
        board.note_child(r);
      end
      if (out_if.valid && out_if.ready) begin
        got.updated = out_if.updated;
        got.wx      = out_if.world_x;
        got.wy      = out_if.world_y;
        got.wa      = out_if.world_angle;
        board.check_result(got);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        hold_count++;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic child_rec_t mk(logic ok, logic [31:0] px, logic [31:0] py,
                                    logic [15:0] pa, logic [31:0] scx, logic [31:0] scy,
                                    logic [31:0] lx, logic [31:0] ly, logic [15:0] la);
    child_rec_t r;
    r.ok = ok; r.px = px; r.py = py; r.pa = pa; r.scx = scx; r.scy = scy;
    r.lx = lx; r.ly = ly; r.la = la;
    return r;
  endfunction

  function automatic logic [31:0] rand_fix(bit is_scale);
    logic [31:0] m;
    case ($urandom_range(9))
      0, 1, 2, 3: m = $urandom;
      4, 5, 6, 7: begin
        m = $urandom_range(0, is_scale ? 32'h40000 : 32'h800000);
        if ($urandom_range(1)) m = -m;
      end
      8: begin
        case ($urandom_range(5))
          0:       m = 32'h7FFFFFFF;
          1:       m = 32'h80000000;
          2:       m = 32'h00000000;
          3:       m = 32'hFFFFFFFF;
          4:       m = 32'h00010000;
          default: m = 32'hFFFF0000;
        endcase
      end
      default: m = $signed($urandom) >>> $urandom_range(0, 16);
    endcase
    return m;
  endfunction

  // quadrant edges get extra weight since they decide the CORDIC fold
  function automatic logic [15:0] rand_angle();
    logic [15:0] a;
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(7))
        0:       a = 16'h0000;
        1:       a = 16'h3FFF;
        2:       a = 16'h4000;
        3:       a = 16'h7FFF;
        4:       a = 16'h8000;
        5:       a = 16'hBFFF;
        6:       a = 16'hC000;
        default: a = 16'hFFFF;
      endcase
    end else begin
      a = $urandom_range(0, 65535);
    end
    return a;
  endfunction

  task automatic push_child(input child_rec_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_if.parent_ok      = r.ok;
    in_if.parent_x       = r.px;
    in_if.parent_y       = r.py;
    in_if.parent_angle   = r.pa;
    in_if.parent_scale_x = r.scx;
    in_if.parent_scale_y = r.scy;
    in_if.local_x        = r.lx;
    in_if.local_y        = r.ly;
    in_if.local_angle    = r.la;
    in_if.valid          = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // sender stops and waits for every pending result
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (board.pending_world.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_burst(input int n, input bit with_hold);
    child_rec_t r;
    for (int k = 0; k < n; k++) begin
      r.ok  = ($urandom_range(99) >= 10);
      r.px  = rand_fix(1'b0);
      r.py  = rand_fix(1'b0);
      r.pa  = rand_angle();
      r.scx = rand_fix(1'b1);
      r.scy = rand_fix(1'b1);
      r.lx  = rand_fix(1'b0);
      r.ly  = rand_fix(1'b0);
      r.la  = rand_angle();
      push_child(r);
      if (with_hold && k == n / 3) begin
        hold_req = 1'b1;
      end
    end
  endtask

  task automatic run_directed();
    // orphans with every field at an extreme
    push_child(mk(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF));
    push_child(mk(1'b0, 32'h80000000, 32'h80000000, 16'h0000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 16'h0000));
    // unit scale, each quadrant and its edges
    push_child(mk(1'b1, 0, 0, 16'h0000, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 16'h0000));
    push_child(mk(1'b1, 0, 0, 16'h3FFF, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 16'h0001));
    push_child(mk(1'b1, 0, 0, 16'h4000, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 16'h1234));
    push_child(mk(1'b1, 0, 0, 16'h7FFF, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 16'h8000));
    push_child(mk(1'b1, 0, 0, 16'h8000, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 16'h8000));
    push_child(mk(1'b1, 0, 0, 16'hBFFF, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 16'h4001));
    push_child(mk(1'b1, 0, 0, 16'hC000, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 16'h4000));
    push_child(mk(1'b1, 0, 0, 16'hFFFF, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 16'h0001));
    // world angle wraps past a full turn
    push_child(mk(1'b1, 32'h50000, 32'hFFFB0000, 16'h8001, 32'h10000, 32'h10000,
                  32'h30000, 32'h0, 16'hFFFF));
    // scaled offset saturates both ways
    push_child(mk(1'b1, 0, 0, 16'h0000, 32'h7FFFFFFF, 32'h80000000,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0000));
    push_child(mk(1'b1, 0, 0, 16'h0000, 32'h80000000, 32'h7FFFFFFF,
                  32'h80000000, 32'h80000000, 16'h0000));
    push_child(mk(1'b1, 0, 0, 16'h2000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h7FFFFFFF, 16'h0000));
    // world position saturates at both rails
    push_child(mk(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0000, 32'h10000, 32'h10000,
                  32'h640000, 32'h640000, 16'h0000));
    push_child(mk(1'b1, 32'h80000000, 32'h80000000, 16'h0000, 32'h10000, 32'h10000,
                  32'hFF9C0000, 32'hFF9C0000, 16'h0000));
    push_child(mk(1'b1, 32'h7FFFFFFF, 32'h80000000, 16'h6000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h80000000, 16'h7FFF));
    // zero and negative scale, minus one and tiny offsets
    push_child(mk(1'b1, 32'h12345678, 32'hEDCBA988, 16'h1555, 32'h0, 32'hFFFF0000,
                  32'h10000, 32'hFFFFFFFF, 16'h0100));
    push_child(mk(1'b1, 32'hFFFFFFFF, 32'h1, 16'hA000, 32'hFFFF0000, 32'hFFFF0000,
                  32'h1, 32'hFFFFFFFF, 16'hF000));
    push_child(mk(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF));
    push_child(mk(1'b1, 32'h80000000, 32'h80000000, 16'h0000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 16'h0000));
    push_child(mk(1'b1, 32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 32'h55555555, 32'hAAAAAAAA,
                  32'h5555AAAA, 32'hAAAA5555, 16'h5555));
  endtask

  initial begin
    board = new();
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.parent_ok      = 1'b0;
    in_if.parent_x       = '0;
    in_if.parent_y       = '0;
    in_if.parent_angle   = '0;
    in_if.parent_scale_x = '0;
    in_if.parent_scale_y = '0;
    in_if.local_x        = '0;
    in_if.local_y        = '0;
    in_if.local_angle    = '0;
    out_if.ready         = 1'b0;
    tx_idle_pct          = 10;
    rx_idle_pct          = 20;
    hold_req             = 1'b0;
    hold_left            = 0;
    hold_count           = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    run_directed();
    wait_drained();

    tx_idle_pct = 32;
    rx_idle_pct = 66;
    random_burst(280, 1'b1);
    wait_drained();

    tx_idle_pct = 66;
    rx_idle_pct = 32;
    random_burst(280, 1'b0);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_burst(290, 1'b1);
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("Covered %0d child records (%0d orphaned) over three stall mixes, %0d output holds",
             board.children, board.orphans, hold_count);
    $display("%0d world transforms compared, %0d mismatches", board.checked, board.errors);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
